@@ rtl/flve_pkg.sv @@
package flve_pkg;

    // Input request and result payloads
    typedef struct packed {
        logic [47:0]        time_us;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic [15:0]        distance_cm;
        logic               distance_valid;
    } t_in;

    typedef struct packed {
        logic signed [15:0] velocity_x_mm_s;
        logic signed [15:0] velocity_y_mm_s;
        logic [15:0]        distance_out;
        logic               distance_ok;
        logic [23:0]        frame_rate;
    } t_out;

    // Configuration register indexes
    localparam logic [2:0] REG_GAIN   = 3'd0;
    localparam logic [2:0] REG_ALPHA  = 3'd1;
    localparam logic [2:0] REG_DECAY  = 3'd2;
    localparam logic [2:0] REG_MINR   = 3'd3;
    localparam logic [2:0] REG_WINDOW = 3'd4;

    localparam logic [23:0] RST_GAIN   = 24'd468114;
    localparam logic [15:0] RST_ALPHA  = 16'd6554;
    localparam logic [15:0] RST_DECAY  = 16'd58982;
    localparam logic [23:0] RST_MINR   = 24'd256;
    localparam logic [23:0] RST_WINDOW = 24'd1000000;

    localparam logic [27:0] RATE_SCALE = 28'd256000000;
    localparam logic [23:0] SAT24      = 24'hFFFFFF;
    localparam logic [4:0]  DIV_LAST   = 5'd23;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CNT, ST_CHK, ST_DSAT, ST_DIV, ST_DFIN, ST_RG, ST_RGL,
        ST_A, ST_AH, ST_AL, ST_MAG, ST_W1, ST_W2, ST_WS, ST_DEC, ST_DECS, ST_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CNT, OP_MDIV, OP_DSAT, OP_DIV, OP_DFIN, OP_MRG,
        OP_LRG, OP_MA, OP_MAH, OP_MAL, OP_MAG, OP_MW1, OP_MW2, OP_WSUM,
        OP_MDEC, OP_DECS, OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic axis;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic sat;
        logic go;
        logic out_free;
    } t_sts;

    // Saturate a wide signed value to the 40-bit smoothed range
    function automatic logic signed [39:0] clamp40(input logic signed [65:0] x);
        logic signed [39:0] res;
        begin
            if (x > 66'sd549755813887) begin
                res = 40'sd549755813887;
            end else if (x < -66'sd549755813888) begin
                res = -40'sd549755813888;
            end else begin
                res = x[39:0];
            end
            return res;
        end
    endfunction

    // Q24.16 to int16, truncated toward zero and saturated
    function automatic logic signed [15:0] to_out16(input logic signed [39:0] s);
        logic [40:0]        mag;
        logic [24:0]        v;
        logic signed [15:0] res;
        begin
            mag = s[39] ? (41'd0 - {s[39], s}) : {1'b0, s};
            v   = mag[40:16];
            if (s[39]) begin
                res = (v > 25'd32768) ? 16'sh8000 : 16'(25'd0 - v);
            end else begin
                res = (v > 25'd32767) ? 16'sh7FFF : v[15:0];
            end
            return res;
        end
    endfunction

endpackage

@@ rtl/flve_ctrl.sv @@
module flve_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  flve_pkg::t_sts i_sts,
    output flve_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import flve_pkg::*;

    t_state r_state, n_state;
    logic [4:0] r_cnt;
    logic       r_axis;

    // Advance state, divider count and axis select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DSAT) begin
                r_cnt <= DIV_LAST;
            end else if (r_state == ST_DIV) begin
                r_cnt <= r_cnt - 5'd1;
            end
            if (r_state == ST_RG) begin
                r_axis <= 1'b0;
            end else if (r_state == ST_WS || r_state == ST_DECS) begin
                r_axis <= ~r_axis;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_CNT;
            ST_CNT:  n_state = ST_CHK;
            ST_CHK:  n_state = i_sts.hit ? ST_DSAT : ST_RG;
            ST_DSAT: n_state = i_sts.sat ? ST_DFIN : ST_DIV;
            ST_DIV:  n_state = (r_cnt == 5'd0) ? ST_DFIN : ST_DIV;
            ST_DFIN: n_state = ST_RG;
            ST_RG:   n_state = i_sts.go ? ST_RGL : ST_DEC;
            ST_RGL:  n_state = ST_A;
            ST_A:    n_state = ST_AH;
            ST_AH:   n_state = ST_AL;
            ST_AL:   n_state = ST_MAG;
            ST_MAG:  n_state = ST_W1;
            ST_W1:   n_state = ST_W2;
            ST_W2:   n_state = ST_WS;
            ST_WS:   n_state = r_axis ? ST_OUT : ST_A;
            ST_DEC:  n_state = ST_DECS;
            ST_DECS: n_state = r_axis ? ST_OUT : ST_DEC;
            ST_OUT:  if (i_sts.out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd.axis = r_axis;
        o_busy     = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: o_cmd.op = i_valid ? OP_LOAD : OP_NONE;
            ST_CNT:  o_cmd.op = OP_CNT;
            ST_CHK:  o_cmd.op = i_sts.hit ? OP_MDIV : OP_NONE;
            ST_DSAT: o_cmd.op = OP_DSAT;
            ST_DIV:  o_cmd.op = OP_DIV;
            ST_DFIN: o_cmd.op = OP_DFIN;
            ST_RG:   o_cmd.op = i_sts.go ? OP_MRG : OP_NONE;
            ST_RGL:  o_cmd.op = OP_LRG;
            ST_A:    o_cmd.op = OP_MA;
            ST_AH:   o_cmd.op = OP_MAH;
            ST_AL:   o_cmd.op = OP_MAL;
            ST_MAG:  o_cmd.op = OP_MAG;
            ST_W1:   o_cmd.op = OP_MW1;
            ST_W2:   o_cmd.op = OP_MW2;
            ST_WS:   o_cmd.op = OP_WSUM;
            ST_DEC:  o_cmd.op = OP_MDEC;
            ST_DECS: o_cmd.op = OP_DECS;
            ST_OUT:  o_cmd.op = i_sts.out_free ? OP_OUT : OP_NONE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

@@ rtl/flve_dp.sv @@
module flve_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  flve_pkg::t_cmd i_cmd,
    input  flve_pkg::t_in  i_data,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [23:0]    i_cfg_data,
    input  logic           i_stall,
    output flve_pkg::t_sts o_sts,
    output flve_pkg::t_out o_data,
    output logic           o_valid
);
    import flve_pkg::*;

    logic [23:0] r_gain, r_minr, r_win;
    logic [15:0] r_alpha, r_decay;
    logic [23:0] r_count, r_rate;
    logic [47:0] r_wstart, r_elapsed;
    logic signed [39:0] r_sx, r_sy;
    logic        r_hit;
    t_in         r_in;
    logic signed [65:0] r_prod, r_acc;
    logic [48:0] r_rem;
    logic [23:0] r_dlo;
    logic [47:0] r_rg;
    logic [31:0] r_a;
    logic [55:0] r_ah;
    logic signed [39:0] r_raw;
    t_out        r_out;
    logic        r_ovalid;

    logic signed [15:0] w_delta;
    logic [16:0]  w_absd;
    logic signed [39:0] w_smooth;
    logic [16:0]  w_wb;
    logic [23:0]  w_win, w_cinc;
    logic [47:0]  w_elapsed;
    logic         w_sat;
    logic [48:0]  w_dnext;
    logic         w_dge;
    logic [48:0]  w_magsum;
    logic [38:0]  w_mag;
    logic [39:0]  w_mag40;
    logic signed [40:0] w_ma;
    logic signed [24:0] w_mb;
    logic signed [65:0] w_prod, w_sum;
    logic signed [39:0] w_snew;

    // Per-axis selection and small helpers
    assign w_delta   = i_cmd.axis ? r_in.delta_y : r_in.delta_x;
    assign w_absd    = w_delta[15] ? (~{1'b1, w_delta} + 17'd1) : {1'b0, w_delta};
    assign w_smooth  = i_cmd.axis ? r_sy : r_sx;
    assign w_wb      = 17'd65536 - {1'b0, r_alpha};
    assign w_win     = (r_win == 24'd0) ? 24'd1 : r_win;
    assign w_cinc    = (r_count != SAT24) ? r_count + 24'd1 : r_count;
    assign w_elapsed = r_in.time_us - r_wstart;
    assign w_sat     = {20'd0, r_prod[51:0]} >= {r_elapsed, 24'd0};
    assign w_dnext   = {r_rem[47:0], r_dlo[23]};
    assign w_dge     = w_dnext >= {1'b0, r_elapsed};

    // Raw velocity magnitude, saturated to 2^39-1
    assign w_magsum = 49'({r_ah[22:0], 16'd0}) + 49'(r_prod[55:8]);
    assign w_mag    = ((|r_ah[55:23]) || (|w_magsum[48:39])) ? {39{1'b1}} : w_magsum[38:0];
    assign w_mag40  = {1'b0, w_mag};

    // Shared multiplier operand select
    always_comb begin
        case (i_cmd.op)
            OP_MDIV: begin w_ma = 41'({13'd0, RATE_SCALE}); w_mb = {1'b0, r_count}; end
            OP_MRG:  begin w_ma = {17'd0, r_rate};          w_mb = {1'b0, r_gain}; end
            OP_MA:   begin w_ma = {24'd0, w_absd};          w_mb = {9'd0, r_in.distance_cm}; end
            OP_MAH:  begin w_ma = {9'd0, r_prod[31:0]};     w_mb = {1'b0, r_rg[47:24]}; end
            OP_MAL:  begin w_ma = {9'd0, r_a};              w_mb = {1'b0, r_rg[23:0]}; end
            OP_MW1:  begin w_ma = {r_raw[39], r_raw};       w_mb = {9'd0, r_alpha}; end
            OP_MW2:  begin w_ma = {w_smooth[39], w_smooth}; w_mb = {8'd0, w_wb}; end
            OP_MDEC: begin w_ma = {w_smooth[39], w_smooth}; w_mb = {9'd0, r_decay}; end
            default: begin w_ma = '0;                       w_mb = '0; end
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign w_sum  = r_acc + r_prod;
    assign w_snew = (i_cmd.op == OP_WSUM) ? clamp40(w_sum >>> 16) : clamp40(r_prod >>> 16);

    // Configuration registers and control-side state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= RST_GAIN;
            r_alpha  <= RST_ALPHA;
            r_decay  <= RST_DECAY;
            r_minr   <= RST_MINR;
            r_win    <= RST_WINDOW;
            r_count  <= '0;
            r_wstart <= '0;
            r_rate   <= '0;
            r_sx     <= '0;
            r_sy     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_GAIN:   r_gain  <= i_cfg_data;
                    REG_ALPHA:  r_alpha <= i_cfg_data[15:0];
                    REG_DECAY:  r_decay <= i_cfg_data[15:0];
                    REG_MINR:   r_minr  <= i_cfg_data;
                    REG_WINDOW: r_win   <= i_cfg_data;
                    default: ;
                endcase
            end
            case (i_cmd.op)
                OP_CNT:  r_count <= w_cinc;
                OP_DFIN: begin
                    r_rate   <= r_dlo;
                    r_count  <= '0;
                    r_wstart <= r_in.time_us;
                end
                OP_WSUM, OP_DECS: begin
                    if (i_cmd.axis) r_sy <= w_snew;
                    else            r_sx <= w_snew;
                end
                default: ;
            endcase
            // Hold the result until taken
            if (i_cmd.op == OP_OUT) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        case (i_cmd.op)
            OP_LOAD: r_in <= i_data;
            OP_CNT: begin
                r_elapsed <= w_elapsed;
                r_hit     <= w_elapsed >= {24'd0, w_win};
            end
            OP_DSAT: begin
                r_rem <= {21'd0, r_prod[51:24]};
                r_dlo <= w_sat ? SAT24 : r_prod[23:0];
            end
            OP_DIV: begin
                r_rem <= w_dge ? (w_dnext - {1'b0, r_elapsed}) : w_dnext;
                r_dlo <= {r_dlo[22:0], w_dge};
            end
            OP_LRG: r_rg  <= r_prod[47:0];
            OP_MAH: r_a   <= r_prod[31:0];
            OP_MAL: r_ah  <= r_prod[55:0];
            OP_MAG: r_raw <= w_delta[15] ? (40'd0 - w_mag40) : w_mag40;
            OP_MW2: r_acc <= r_prod;
            OP_OUT: begin
                r_out.velocity_x_mm_s <= to_out16(r_sx);
                r_out.velocity_y_mm_s <= to_out16(r_sy);
                r_out.distance_out    <= r_in.distance_cm;
                r_out.distance_ok     <= r_in.distance_valid;
                r_out.frame_rate      <= r_rate;
            end
            default: ;
        endcase
    end

    assign o_sts.hit      = r_hit;
    assign o_sts.sat      = w_sat;
    assign o_sts.go       = r_in.distance_valid && (r_rate > r_minr);
    assign o_sts.out_free = !r_ovalid || !i_stall;
    assign o_data         = r_out;
    assign o_valid        = r_ovalid;

endmodule

@@ rtl/flow_lidar_velocity_estimator_core.sv @@
// One request at a time: a result comes from the decay path, from a velocity
// update, or, when the rate window closes, after the rate division as well
// (24-step restoring divider). The block takes no new request until the last
// one is through; the divider and the single shared 41x25 multiplier set the pace.
// A result may wait in the output register and holds the next one until taken.
// Reset (synchronous, active low) restores register defaults and clears state.
module flow_lidar_velocity_estimator_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  flve_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output flve_pkg::t_out  o_data,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [23:0]     i_cfg_data
);
    import flve_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_busy;

    flve_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (w_busy)
    );

    flve_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_data     (i_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_stall    (i_stall),
        .o_sts      (w_sts),
        .o_data     (o_data),
        .o_valid    (o_valid)
    );

    assign o_stall = w_busy;

`ifndef ASSERT_OFF
    // An accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after accept");

    // A new result is only produced by a request in flight
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without request in flight");
`endif

endmodule

@@ sim/flve_checker.sv @@
module flve_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_stall_in,
    input  flve_pkg::t_in   i_req,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  flve_pkg::t_out  i_res,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [23:0]     i_cfg_data,
    output int              o_errors,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import flve_pkg::*;

    localparam longint RAW_MAX = 64'sd549755813887;

    // Configuration and state copies
    logic [23:0] gain, minr, win_us;
    logic [15:0] alpha, decay;
    logic [23:0] count, rate;
    logic [47:0] win_start;
    longint      sx, sy;
    t_out        expected_q[$];

    assign o_pending = expected_q.size();

    function automatic longint floor16(longint x);
        return x >>> 16;
    endfunction

    function automatic longint clamp_raw(longint x);
        if (x > RAW_MAX) return RAW_MAX;
        if (x < -RAW_MAX - 1) return -RAW_MAX - 1;
        return x;
    endfunction

    // Raw velocity: |delta|*dist_cm*rate*gain, 24 fraction bits down to 16
    function automatic longint raw_vel(logic signed [15:0] d, logic [15:0] dist_cm,
                                       logic [47:0] rg);
        logic          neg;
        logic [63:0]   a, ah, mag;
        logic [127:0]  wide;
        begin
            neg  = d < 0;
            a    = (neg ? -longint'(d) : longint'(d)) * dist_cm;
            ah   = a * (rg >> 24);
            if (ah >= 64'd8388608) begin
                mag = RAW_MAX;
            end else begin
                wide = {64'd0, ah << 16} + ((128'(a) * rg[23:0]) >> 8);
                mag  = (wide > RAW_MAX) ? RAW_MAX : wide[63:0];
            end
            return neg ? -longint'(mag) : longint'(mag);
        end
    endfunction

    function automatic logic [15:0] sat16(longint s);
        longint v;
        begin
            v = (s >= 0) ? (s >>> 16) : -((-s) >>> 16);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[15:0];
        end
    endfunction

    // Advance the velocity estimate by one reading
    function automatic t_out estimate(t_in r);
        t_out        o;
        logic [47:0] elapsed, w;
        logic [63:0] q;
        longint      rx, ry, wa;
        logic [47:0] rg;
        begin
            w       = (win_us == 0) ? 48'd1 : 48'(win_us);
            elapsed = r.time_us - win_start;
            if (count != 24'hFFFFFF) count = count + 24'd1;
            if (elapsed >= w) begin
                q         = (64'(count) * 64'd256000000) / 64'(elapsed);
                rate      = (q > 64'hFFFFFF) ? 24'hFFFFFF : q[23:0];
                count     = '0;
                win_start = r.time_us;
            end
            if (r.distance_valid && rate > minr) begin
                rg = 48'(rate) * 48'(gain);
                rx = raw_vel(r.delta_x, r.distance_cm, rg);
                ry = raw_vel(r.delta_y, r.distance_cm, rg);
                wa = alpha;
                sx = clamp_raw(floor16(wa * rx + (65536 - wa) * sx));
                sy = clamp_raw(floor16(wa * ry + (65536 - wa) * sy));
            end else begin
                sx = clamp_raw(floor16(sx * longint'(decay)));
                sy = clamp_raw(floor16(sy * longint'(decay)));
            end
            o.velocity_x_mm_s = sat16(sx);
            o.velocity_y_mm_s = sat16(sy);
            o.distance_out    = r.distance_cm;
            o.distance_ok     = r.distance_valid;
            o.frame_rate      = rate;
            return o;
        end
    endfunction

    // Track configuration, predict on request, compare on result
    always @(posedge i_clk) begin
        t_out exp_res;
        if (!i_rst_n) begin
            gain = RST_GAIN; alpha = RST_ALPHA; decay = RST_DECAY;
            minr = RST_MINR; win_us = RST_WINDOW;
            count = '0; rate = '0; win_start = '0; sx = 0; sy = 0;
            expected_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_GAIN:   gain   = i_cfg_data;
                    REG_ALPHA:  alpha  = i_cfg_data[15:0];
                    REG_DECAY:  decay  = i_cfg_data[15:0];
                    REG_MINR:   minr   = i_cfg_data;
                    REG_WINDOW: win_us = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in) expected_q.push_back(estimate(i_req));
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %p", i_res);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_res = expected_q.pop_front();
                    if (exp_res !== i_res) begin
                        if (o_errors < 10)
                            $display("mismatch: expected %p got %p", exp_res, i_res);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

@@ sim/flow_lidar_velocity_estimator_core_tb.sv @@
module flow_lidar_velocity_estimator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import flve_pkg::*;

    // Index outside the register list
    localparam logic [2:0] REG_NONE = 3'd7;

    logic        clk, rst_n;
    logic        in_valid, in_stall, out_valid, out_stall;
    t_in         req;
    t_out        res;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [23:0] cfg_data;
    int          errors, pending;
    logic        hold_off;
    logic [47:0] now_us;

    flow_lidar_velocity_estimator_core i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_data(req),
        .o_valid(out_valid), .i_stall(out_stall), .o_data(res),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    flve_checker i_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_stall_in(in_stall), .i_req(req),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_res(res),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    function automatic int gap_len();
        int p;
        begin
            p = $urandom_range(0, 99);
            if (p < 40) return 0;
            if (p < 95) return $urandom_range(1, 4);
            return $urandom_range(20, 120);
        end
    endfunction

    // Result-side stall, with one long hold-off on request
    initial begin
        int g;
        out_stall = 0;
        forever begin
            @(posedge clk);
            if (hold_off) begin
                out_stall <= 1;
                repeat (400) @(posedge clk);
                out_stall <= 0;
                @(posedge clk);
            end else if ($urandom_range(0, 3) == 0) begin
                g = gap_len();
                if (g > 0) begin
                    out_stall <= 1;
                    repeat (g) @(posedge clk);
                    out_stall <= 0;
                end
            end
        end
    end

    task automatic send(t_in r);
        int g;
        begin
            g = gap_len();
            if (g > 0) begin
                in_valid <= 0;
                repeat (g) @(posedge clk);
            end
            req      <= r;
            in_valid <= 1;
            @(posedge clk);
            while (in_stall) @(posedge clk);
        end
    endtask

    task automatic drain();
        begin
            in_valid <= 0;
            @(posedge clk);
            while (pending != 0) @(posedge clk);
            repeat (60) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        begin
            cfg_we   <= 1;
            cfg_idx  <= idx;
            cfg_data <= val;
            @(posedge clk);
            cfg_we   <= 0;
            @(posedge clk);
        end
    endtask

    // Mostly forward time steps around the window, sometimes backward or huge
    function automatic t_in rand_req(int mode);
        t_in r;
        int  p;
        begin
            p = $urandom_range(0, 99);
            if (p < 80) now_us = now_us + $urandom_range(0, 4000 * (mode + 1));
            else if (p < 90) now_us = now_us + $urandom_range(0, 2000000);
            else if (p < 95) now_us = 48'({$urandom, $urandom});
            else now_us = now_us - $urandom_range(0, 1000);
            r.time_us        = now_us;
            r.delta_x        = (p % 7 == 0) ? 16'($urandom) :
                               16'($urandom_range(0, 200) - 100);
            r.delta_y        = (p % 5 == 0) ? 16'($urandom) :
                               16'($urandom_range(0, 200) - 100);
            r.distance_cm    = (p % 3 == 0) ? 16'($urandom) : 16'($urandom_range(0, 1000));
            r.distance_valid = ($urandom_range(0, 9) != 0);
            return r;
        end
    endfunction

    function automatic t_in mk(logic [47:0] t, logic signed [15:0] dx,
                               logic signed [15:0] dy, logic [15:0] d, logic v);
        t_in r;
        begin
            r.time_us = t; r.delta_x = dx; r.delta_y = dy;
            r.distance_cm = d; r.distance_valid = v;
            return r;
        end
    endfunction

    initial begin
        rst_n = 0; in_valid = 0; req = '0; hold_off = 0;
        cfg_we = 0; cfg_idx = REG_GAIN; cfg_data = 0; now_us = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: defaults, short window, extremes, wrap and backward time
        write_reg(REG_WINDOW, 24'd0);
        write_reg(REG_MINR, 24'd0);
        send(mk(48'd0, 16'sd5, -16'sd5, 16'd100, 1'b1));
        send(mk(48'd10, 16'sd32767, -16'sd32768, 16'hFFFF, 1'b1));
        send(mk(48'd11, -16'sd32768, 16'sd32767, 16'hFFFF, 1'b1));
        send(mk(48'd11, 16'sd0, 16'sd0, 16'd0, 1'b0));
        send(mk(48'hFFFFFFFFFFFF, 16'sd1, -16'sd1, 16'd50, 1'b1));
        send(mk(48'd3, 16'sd100, 16'sd100, 16'd500, 1'b1));
        send(mk(48'd1, 16'sd100, 16'sd100, 16'd500, 1'b0));
        drain();
        write_reg(REG_GAIN, 24'hFFFFFF);
        write_reg(REG_ALPHA, 24'hFFFF);
        write_reg(REG_DECAY, 24'hFFFF);
        write_reg(REG_WINDOW, 24'hFFFFFF);
        send(mk(48'd2000000, 16'sd32767, -16'sd32768, 16'hFFFF, 1'b1));
        send(mk(48'd40000000, 16'sd32767, -16'sd32768, 16'hFFFF, 1'b1));
        send(mk(48'd40000001, 16'sd0, 16'sd0, 16'd0, 1'b0));
        drain();
        write_reg(REG_MINR, 24'hFFFFFF);
        write_reg(REG_ALPHA, 24'd0);
        write_reg(REG_DECAY, 24'd0);
        send(mk(48'd40000002, 16'sd1, 16'sd1, 16'd1, 1'b1));
        drain();
        now_us = 48'd50000000;

        // Random phases over several register settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_GAIN, (ph == 0) ? 24'd0 : 24'($urandom_range(0, 24'hFFFFFF)));
            write_reg(REG_ALPHA, (ph == 1) ? 24'hFFFF : 24'($urandom_range(0, 65535)));
            write_reg(REG_DECAY, (ph == 2) ? 24'd0 : 24'($urandom_range(30000, 65535)));
            write_reg(REG_MINR, (ph % 3 == 0) ? 24'd0 : 24'($urandom_range(0, 30000)));
            write_reg(REG_WINDOW, (ph == 3) ? 24'd1 : 24'($urandom_range(1, 50000)));
            write_reg(REG_NONE, 24'hFFFFFF);
            if (ph == 4) hold_off = 1;
            for (int k = 0; k < 100; k++) begin
                send(rand_req(ph % 3));
                if (k == 2) hold_off = 0;
            end
            drain();
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

@@ files.f @@
rtl/flve_pkg.sv
rtl/flve_ctrl.sv
rtl/flve_dp.sv
rtl/flow_lidar_velocity_estimator_core.sv
sim/flve_checker.sv
sim/flow_lidar_velocity_estimator_core_tb.sv
